/* rtl/fixed_point_mul_div_unit_macros.svh */
// Assertion macros for the fixed-point multiply/divide unit checker.
// No dependencies.
`ifndef FIXED_POINT_MUL_DIV_UNIT_MACROS_SVH
`define FIXED_POINT_MUL_DIV_UNIT_MACROS_SVH

// Implication checked while out of reset.
`define FPMD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fpmd assertion failed");

// Next-cycle implication, active through reset.
`define FPMD_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fpmd assertion failed");

`endif

/* rtl/fpmd_pkg.sv */
// Package for the fixed-point multiply/divide unit: beat types, op codes,
// pipeline lane type and sizing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpmd_pkg;

    localparam int DataWidthDefault = 32;
    localparam int DIV_STEPS  = 64;   // one quotient bit per stage
    localparam int SQRT_STEPS = 16;   // one root bit per stage

    typedef enum logic [2:0] {
        FN_MULSCALE  = 3'd0,
        FN_DMULSCALE = 3'd1,
        FN_DIVSCALE  = 3'd2,
        FN_SCALE     = 3'd3,
        FN_SQRT      = 3'd4,
        FN_ABS       = 3'd5,
        FN_SIGN      = 3'd6
    } fpmd_func_t;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic [5:0]         shift;
    } fpmd_in_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               div_by_zero;
    } fpmd_out_t;

    // State carried through the divide / root stages.
    typedef struct packed {
        logic [2:0]  func;
        logic        dz;
        logic        neg;
        logic        a_neg;
        logic [31:0] direct;
        logic [31:0] rem;
        logic [63:0] num;
        logic [31:0] den;
        logic [31:0] sq_x;
        logic [31:0] sq_res;
    } fpmd_lane_t;

endpackage

`default_nettype wire

/* rtl/fixed_point_mul_div_unit.sv */
// Fixed-point multiply / shift / divide / root unit, top level.
// Depends on fpmd_pkg and fpmd_step.
//
// Usage:
//   s_ channel (s_valid/s_ready/s_data) takes one request beat: func, a, b,
//   c, d, shift. m_channel (m_valid/m_ready/m_data) returns one beat per
//   request: result and div_by_zero, in request order.
//   Throughput: one beat per cycle, sustained, with m_ready held high.
//   Stages from s_ accept to m_valid: one multiply stage, one
//   add/select stage, one shift/magnitude stage, 64 divide stages (one
//   quotient bit each, the first 16 also doing one root bit), and the
//   output register. Every op runs the full pipe.
//   Stall: when m_valid is high and m_ready low the whole pipe freezes and
//   s_ready drops in the same cycle; nothing is lost or repeated.
//   s_ready = !m_valid || m_ready.
//   Reset (aresetn low, synchronous) empties the pipe; no other state.
//   Zero divisor gives result 0 with div_by_zero set. Results are the low
//   DATA_WIDTH bits, sign-extended to 32.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_mul_div_unit
    import fpmd_pkg::*;
#(
    parameter int DATA_WIDTH = DataWidthDefault
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire fpmd_in_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output fpmd_out_t     m_data
);

    logic en;

    // stage 1: products
    logic               s1_valid_reg;
    logic [2:0]         s1_func_reg;
    logic signed [31:0] s1_a_reg;
    logic signed [31:0] s1_b_reg;
    logic signed [31:0] s1_c_reg;
    logic [5:0]         s1_shift_reg;
    logic signed [63:0] s1_pab_reg;
    logic signed [63:0] s1_pcd_reg;
    logic signed [63:0] pab_next;
    logic signed [63:0] pcd_next;

    // stage 2: sum and dividend select
    logic               s2_valid_reg;
    logic [2:0]         s2_func_reg;
    logic signed [31:0] s2_a_reg;
    logic [5:0]         s2_shift_reg;
    logic signed [64:0] s2_val_reg;
    logic [63:0]        s2_dvd_reg;
    logic [31:0]        s2_dsr_reg;
    logic               s2_dz_reg;
    logic signed [64:0] val_next;
    logic [63:0]        dvd_next;
    logic [31:0]        dsr_next;
    logic               dz_next;

    // stage 3 lane and divide/root stages
    fpmd_lane_t lane_in;
    logic signed [64:0] shifted;
    logic               lane0_valid_reg;
    fpmd_lane_t         lane0_reg;
    logic               lane_valid [DIV_STEPS+1];
    fpmd_lane_t         lane       [DIV_STEPS+1];

    // output
    logic               m_valid_reg;
    fpmd_out_t          m_data_reg;
    fpmd_out_t          m_data_next;
    logic [31:0]        qlow;
    logic [31:0]        raw;
    logic signed [DATA_WIDTH-1:0] fit;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign pab_next = s_data.a * s_data.b;
    assign pcd_next = s_data.c * s_data.d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            lane0_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else if (en) begin
            s1_valid_reg    <= s_valid;
            s2_valid_reg    <= s1_valid_reg;
            lane0_valid_reg <= s2_valid_reg;
            m_valid_reg     <= lane_valid[DIV_STEPS];
        end
        if (en) begin
            s1_func_reg  <= s_data.func;
            s1_a_reg     <= s_data.a;
            s1_b_reg     <= s_data.b;
            s1_c_reg     <= s_data.c;
            s1_shift_reg <= s_data.shift;
            s1_pab_reg   <= pab_next;
            s1_pcd_reg   <= pcd_next;
            s2_func_reg  <= s1_func_reg;
            s2_a_reg     <= s1_a_reg;
            s2_shift_reg <= s1_shift_reg;
            s2_val_reg   <= val_next;
            s2_dvd_reg   <= dvd_next;
            s2_dsr_reg   <= dsr_next;
            s2_dz_reg    <= dz_next;
            lane0_reg    <= lane_in;
            m_data_reg   <= m_data_next;
        end
    end

    assign lane_valid[0] = lane0_valid_reg;
    assign lane[0]       = lane0_reg;

    // stage 2: 65-bit sum (dmulscale), dividend and divisor pick
    always_comb begin
        if (s1_func_reg == FN_DMULSCALE) begin
            val_next = {s1_pab_reg[63], s1_pab_reg} + {s1_pcd_reg[63], s1_pcd_reg};
        end else begin
            val_next = {s1_pab_reg[63], s1_pab_reg};
        end
        if (s1_func_reg == FN_DIVSCALE) begin
            dvd_next = 64'(s1_a_reg) << s1_shift_reg;
            dsr_next = s1_b_reg;
        end else begin
            dvd_next = s1_pab_reg;
            dsr_next = s1_c_reg;
        end
        dz_next = (dsr_next == 32'd0) &&
                  (s1_func_reg == FN_DIVSCALE || s1_func_reg == FN_SCALE);
    end

    // stage 3: shift, magnitudes, small ops
    always_comb begin
        shifted        = s2_val_reg >>> s2_shift_reg;
        lane_in.func   = s2_func_reg;
        lane_in.dz     = s2_dz_reg;
        lane_in.neg    = s2_dvd_reg[63] ^ s2_dsr_reg[31];
        lane_in.a_neg  = s2_a_reg[31];
        lane_in.rem    = 32'd0;
        lane_in.num    = s2_dvd_reg[63] ? (64'd0 - s2_dvd_reg) : s2_dvd_reg;
        lane_in.den    = s2_dsr_reg[31] ? (32'd0 - s2_dsr_reg) : s2_dsr_reg;
        lane_in.sq_x   = s2_a_reg;
        lane_in.sq_res = 32'd0;
        case (s2_func_reg)
            FN_MULSCALE, FN_DMULSCALE: lane_in.direct = shifted[31:0];
            FN_ABS:  lane_in.direct = s2_a_reg[31] ? (32'd0 - s2_a_reg) : s2_a_reg;
            FN_SIGN: lane_in.direct = s2_a_reg[31] ? 32'hFFFF_FFFF : 32'd1;
            FN_SQRT: lane_in.direct = 32'd1;
            default: lane_in.direct = 32'd0;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DIV_STEPS; gi++) begin : g_step
            fpmd_step #(.STEP(gi)) u_step (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (en),
                .in_valid (lane_valid[gi]),
                .in_lane  (lane[gi]),
                .out_valid(lane_valid[gi+1]),
                .out_lane (lane[gi+1])
            );
        end
    endgenerate

    // final select, quotient sign, width fit
    always_comb begin
        qlow = lane[DIV_STEPS].neg ? (32'd0 - lane[DIV_STEPS].num[31:0])
                                   : lane[DIV_STEPS].num[31:0];
        case (lane[DIV_STEPS].func)
            FN_MULSCALE, FN_DMULSCALE, FN_ABS, FN_SIGN: raw = lane[DIV_STEPS].direct;
            FN_DIVSCALE, FN_SCALE: raw = lane[DIV_STEPS].dz ? 32'd0 : qlow;
            FN_SQRT: raw = lane[DIV_STEPS].a_neg ? lane[DIV_STEPS].direct
                                                 : lane[DIV_STEPS].sq_res;
            default: raw = 32'd0;
        endcase
        fit = raw[DATA_WIDTH-1:0];
        m_data_next.result      = 32'(fit);
        m_data_next.div_by_zero = lane[DIV_STEPS].dz;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* rtl/fpmd_step.sv */
// One stage of the divide / square-root pipeline: a restoring divide step,
// plus one root step in the first stages. Depends on fpmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpmd_step
    import fpmd_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire fpmd_lane_t in_lane,
    output logic            out_valid,
    output fpmd_lane_t      out_lane
);

    localparam bit          HAS_SQRT = (STEP < SQRT_STEPS);
    localparam logic [31:0] SQ_BIT   =
        HAS_SQRT ? (32'd1 << (30 - 2 * (STEP % SQRT_STEPS))) : 32'd0;

    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;
    logic [31:0] sq_t;
    fpmd_lane_t  lane_next;
    logic        valid_reg;
    fpmd_lane_t  lane_reg;

    always_comb begin
        lane_next = in_lane;
        rem_sh    = {in_lane.rem, in_lane.num[63]};
        rem_sub   = rem_sh - {1'b0, in_lane.den};
        ge        = (rem_sh >= {1'b0, in_lane.den});
        lane_next.rem = ge ? rem_sub[31:0] : rem_sh[31:0];
        lane_next.num = {in_lane.num[62:0], ge};
        sq_t = in_lane.sq_res + SQ_BIT;
        if (HAS_SQRT) begin
            if (in_lane.sq_x >= sq_t) begin
                lane_next.sq_x   = in_lane.sq_x - sq_t;
                lane_next.sq_res = (in_lane.sq_res >> 1) + SQ_BIT;
            end else begin
                lane_next.sq_res = in_lane.sq_res >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

`default_nettype wire

/* rtl/fpmd_checker.sv */
// Port-level checker for the fixed-point multiply/divide unit, bound to the
// top level. Depends on fpmd_pkg and fixed_point_mul_div_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_mul_div_unit_macros.svh"

module fpmd_port_checker
    import fpmd_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire fpmd_in_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire fpmd_out_t m_data
);

    // a held output beat stays put
    `FPMD_ASSERT_NXT(a_out_hold, aclk, aresetn && m_valid && !m_ready, m_valid && $stable(m_data))
    // input is taken exactly when the output side can move
    `FPMD_ASSERT_IMP(a_ready_flow, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready))
    // zero divisor gives zero result
    `FPMD_ASSERT_IMP(a_dz_zero, aclk, aresetn, m_valid && m_data.div_by_zero, m_data.result == 32'sd0)
    // reset empties the pipe
    `FPMD_ASSERT_NXT(a_rst_empty, aclk, !aresetn, !m_valid)

endmodule

bind fixed_point_mul_div_unit fpmd_port_checker u_fpmd_checker (.*);

`default_nettype wire
